// ===== src/ini_line_tokenizer_macros.svh =====
// Shared assertion macros for the line tokenizer.
`ifndef INI_LINE_TOKENIZER_MACROS_SVH
`define INI_LINE_TOKENIZER_MACROS_SVH

// Check on every clock edge outside reset.
`define ILT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ILT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ilt_pkg.sv =====
`default_nettype none

package ilt_pkg;

  localparam int SPAN_W = 11;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_OPEN   = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE  = 8'h5D;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_EQUALS = 8'h3D;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SYNTAX   = 2'd1,
    STATUS_BLANK    = 2'd2,
    STATUS_TOO_LONG = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_OPEN    = 3'd1,
    MODE_CLOSED  = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_EQUALS  = 3'd4,
    MODE_TEXT    = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic              section_found;
    logic [SPAN_W-1:0] section_start;
    logic [SPAN_W-1:0] section_stop;
    logic              key_found;
    logic [SPAN_W-1:0] key_start;
    logic [SPAN_W-1:0] key_stop;
    logic              value_found;
    logic [SPAN_W-1:0] value_start;
    logic [SPAN_W-1:0] value_stop;
  } out_t;

endpackage

`default_nettype wire

// ===== src/ini_line_tokenizer.sv =====
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall   ilt_pkg::in_t  (char_code, line_end)
// out_     output     out_valid/out_stall ilt_pkg::out_t (status, section, key, value)
//
// One character per cycle unless stalled; a result registers as its line end is taken.
// The per-character state update is one registered step after the input register.
// A line's last character waits in the input register while a stalled result is held.
// Synchronous active-low reset clears both registers' valids and the line state.
// Input stays open while a result is stalled, until the next line end arrives.
`default_nettype none

module ini_line_tokenizer #(
  parameter int MAX_LINE = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire ilt_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output ilt_pkg::out_t     out_data
);

  logic          item_valid;
  ilt_pkg::in_t  item_data;
  logic          item_take;
  logic          res_valid;
  logic          res_free;
  ilt_pkg::out_t res_data;

  ilt_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_data  (item_data),
    .item_take  (item_take)
  );

  ilt_parser #(
    .MAX_LINE (MAX_LINE)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_data  (item_data),
    .item_take  (item_take),
    .res_free   (res_free),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  ilt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/ilt_in_stage.sv =====
`default_nettype none

module ilt_in_stage (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire ilt_pkg::in_t in_data,
  output logic              item_valid,
  output ilt_pkg::in_t      item_data,
  input  wire logic         item_take
);

  logic         item_valid_r;
  logic         item_valid_nxt;
  ilt_pkg::in_t item_data_r;
  logic         load;

  assign in_stall = item_valid_r && !item_take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      item_valid_nxt = 1'b1;
    end else if (item_take) begin
      item_valid_nxt = 1'b0;
    end else begin
      item_valid_nxt = item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_data_r <= in_data;
    end
  end

  assign item_valid = item_valid_r;
  assign item_data  = item_data_r;

endmodule

`default_nettype wire

// ===== src/ilt_parser.sv =====
`default_nettype none

module ilt_parser #(
  parameter int MAX_LINE = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         item_valid,
  input  wire ilt_pkg::in_t item_data,
  output logic              item_take,
  input  wire logic         res_free,
  output logic              res_valid,
  output ilt_pkg::out_t     res_data
);

  `include "ini_line_tokenizer_macros.svh"

  localparam int PW = $clog2(MAX_LINE + 1);

  ilt_pkg::mode_t mode_r, mode_nxt, mode_step;
  logic           stopped_r, stopped_nxt;
  logic           failed_r, failed_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [PW-1:0]  span_begin_r, span_begin_nxt;
  logic [PW-1:0]  span_end_r, span_end_nxt;
  logic           section_seen_r, section_seen_nxt;
  logic [PW-1:0]  section_from_r, section_from_nxt;
  logic [PW-1:0]  section_to_r, section_to_nxt;
  logic [PW-1:0]  key_from_r, key_from_nxt;
  logic [PW-1:0]  key_to_r, key_to_nxt;
  logic [PW-1:0]  text_end_r, text_end_nxt;
  logic           saw_text_r, saw_text_nxt;

  logic [7:0]     c;
  logic           too_long;
  logic           live;
  logic           is_text;
  logic [PW-1:0]  sb_pre;
  logic [PW-1:0]  sb_step;
  logic [PW-1:0]  se_step;
  logic           fail_hit;
  logic           line_done;

  assign c         = item_data.char_code;
  assign too_long  = pos_r >= PW'(MAX_LINE);
  assign live      = !too_long;
  assign is_text   = live && (c != ilt_pkg::CHAR_SPACE);
  assign sb_pre    = (is_text && !saw_text_r) ? pos_r : span_begin_r;
  assign item_take = item_valid && (!item_data.line_end || res_free);
  assign line_done = item_take && item_data.line_end;
  assign res_valid = line_done;

  // next mode, span bounds and syntax error for the current byte
  always_comb begin
    mode_step = mode_r;
    sb_step   = sb_pre;
    se_step   = span_end_r;
    fail_hit  = 1'b0;
    if (c == ilt_pkg::CHAR_SPACE) begin
      mode_step = mode_r;
    end else if (c == ilt_pkg::CHAR_OPEN) begin
      if (mode_r != ilt_pkg::MODE_TEXT) begin
        sb_step   = pos_r;
        mode_step = ilt_pkg::MODE_OPEN;
      end
    end else if (c == ilt_pkg::CHAR_CLOSE) begin
      if (mode_r != ilt_pkg::MODE_TEXT) begin
        if (mode_r != ilt_pkg::MODE_OPEN) begin
          fail_hit = 1'b1;
        end else begin
          mode_step = ilt_pkg::MODE_CLOSED;
          se_step   = pos_r;
        end
      end
    end else if (c == ilt_pkg::CHAR_HASH) begin
      if (mode_r == ilt_pkg::MODE_OPEN) begin
        fail_hit = 1'b1;
      end else begin
        mode_step = ilt_pkg::MODE_COMMENT;
        se_step   = pos_r;
      end
    end else if (c == ilt_pkg::CHAR_EQUALS) begin
      if (mode_r != ilt_pkg::MODE_OPEN && mode_r != ilt_pkg::MODE_COMMENT) begin
        mode_step = ilt_pkg::MODE_EQUALS;
        se_step   = pos_r;
      end
    end else begin
      if (mode_r == ilt_pkg::MODE_CLOSED) begin
        fail_hit = 1'b1;
      end else if (mode_r == ilt_pkg::MODE_INIT || mode_r == ilt_pkg::MODE_EQUALS) begin
        sb_step   = pos_r;
        mode_step = ilt_pkg::MODE_TEXT;
      end
    end
  end

  // line state update and result
  always_comb begin
    mode_nxt         = mode_r;
    stopped_nxt      = stopped_r;
    failed_nxt       = failed_r;
    span_begin_nxt   = sb_pre;
    span_end_nxt     = span_end_r;
    section_seen_nxt = section_seen_r;
    section_from_nxt = section_from_r;
    section_to_nxt   = section_to_r;
    key_from_nxt     = key_from_r;
    key_to_nxt       = key_to_r;
    saw_text_nxt     = saw_text_r || is_text;
    text_end_nxt     = is_text ? PW'(pos_r + 1'b1) : text_end_r;
    pos_nxt          = live ? PW'(pos_r + 1'b1) : pos_r;

    if (live && !stopped_r) begin
      if (fail_hit) begin
        failed_nxt  = 1'b1;
        stopped_nxt = 1'b1;
      end else begin
        mode_nxt       = mode_step;
        span_begin_nxt = sb_step;
        span_end_nxt   = se_step;
        if (mode_step == ilt_pkg::MODE_COMMENT) begin
          stopped_nxt = 1'b1;
        end else if (mode_step == ilt_pkg::MODE_CLOSED) begin
          section_seen_nxt = 1'b1;
          section_from_nxt = PW'(sb_step + 1'b1);
          section_to_nxt   = se_step;
        end else if (mode_step == ilt_pkg::MODE_EQUALS) begin
          key_from_nxt = sb_step;
          key_to_nxt   = se_step;
        end
      end
    end

    res_data = '0;
    if (too_long) begin
      res_data.status = ilt_pkg::STATUS_TOO_LONG;
    end else if (!saw_text_nxt) begin
      res_data.status = ilt_pkg::STATUS_BLANK;
    end else begin
      res_data.status = failed_nxt ? ilt_pkg::STATUS_SYNTAX : ilt_pkg::STATUS_OK;
      if (section_seen_nxt) begin
        res_data.section_found = 1'b1;
        res_data.section_start = ilt_pkg::SPAN_W'(section_from_nxt);
        res_data.section_stop  = ilt_pkg::SPAN_W'(section_to_nxt);
      end
      if (!failed_nxt && key_to_nxt > key_from_nxt) begin
        res_data.key_found = 1'b1;
        res_data.key_start = ilt_pkg::SPAN_W'(key_from_nxt);
        res_data.key_stop  = ilt_pkg::SPAN_W'(key_to_nxt);
        if (mode_nxt == ilt_pkg::MODE_COMMENT || mode_nxt == ilt_pkg::MODE_TEXT) begin
          res_data.value_found = 1'b1;
          res_data.value_start = ilt_pkg::SPAN_W'(span_begin_nxt);
          res_data.value_stop  = (span_end_nxt > span_begin_nxt) ?
                                 ilt_pkg::SPAN_W'(span_end_nxt) :
                                 ilt_pkg::SPAN_W'(text_end_nxt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || line_done) begin
      mode_r         <= ilt_pkg::MODE_INIT;
      stopped_r      <= 1'b0;
      failed_r       <= 1'b0;
      pos_r          <= '0;
      span_begin_r   <= '0;
      span_end_r     <= '0;
      section_seen_r <= 1'b0;
      section_from_r <= '0;
      section_to_r   <= '0;
      key_from_r     <= '0;
      key_to_r       <= '0;
      text_end_r     <= '0;
      saw_text_r     <= 1'b0;
    end else if (item_take) begin
      mode_r         <= mode_nxt;
      stopped_r      <= stopped_nxt;
      failed_r       <= failed_nxt;
      pos_r          <= pos_nxt;
      span_begin_r   <= span_begin_nxt;
      span_end_r     <= span_end_nxt;
      section_seen_r <= section_seen_nxt;
      section_from_r <= section_from_nxt;
      section_to_r   <= section_to_nxt;
      key_from_r     <= key_from_nxt;
      key_to_r       <= key_to_nxt;
      text_end_r     <= text_end_nxt;
      saw_text_r     <= saw_text_nxt;
    end
  end

  `ILT_ASSERT(a_fail_stops, failed_r |-> stopped_r, "syntax error without stop")
  `ILT_ASSERT(a_stop_cause, stopped_r |-> (failed_r || mode_r == ilt_pkg::MODE_COMMENT), "stopped without cause")
  `ILT_ASSERT(a_line_clear, line_done |=> (pos_r == '0 && !saw_text_r && !stopped_r), "line state not cleared")
  `ILT_ASSERT_ALWAYS(a_pos_range, !rst_n || pos_r <= PW'(MAX_LINE), "position past line limit")

endmodule

`default_nettype wire

// ===== src/ilt_out_stage.sv =====
`default_nettype none

module ilt_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          res_valid,
  input  wire ilt_pkg::out_t res_data,
  output logic               res_free,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ilt_pkg::out_t      out_data
);

  logic          out_valid_r;
  logic          out_valid_nxt;
  ilt_pkg::out_t out_data_r;

  assign res_free = !out_valid_r || !out_stall;

  always_comb begin
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== tb/tb_ini_line_tokenizer.sv =====
`timescale 1ns / 100ps

module tb_ini_line_tokenizer;

  localparam int LINE_LIMIT = 1024;
  localparam int IDLE_PCT = 29;
  localparam int RANDOM_CHARS = 150;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  ilt_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  ilt_pkg::out_t out_data;

  ini_line_tokenizer #(.MAX_LINE(LINE_LIMIT)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ilt_pkg::mode_t tok_mode;
  logic tok_halted;
  logic tok_error;
  logic [ilt_pkg::SPAN_W-1:0] tok_pos;
  logic [ilt_pkg::SPAN_W-1:0] tok_begin;
  logic [ilt_pkg::SPAN_W-1:0] tok_end;
  logic tok_sect_seen;
  logic [ilt_pkg::SPAN_W-1:0] tok_sect_lo;
  logic [ilt_pkg::SPAN_W-1:0] tok_sect_hi;
  logic [ilt_pkg::SPAN_W-1:0] tok_key_lo;
  logic [ilt_pkg::SPAN_W-1:0] tok_key_hi;
  logic [ilt_pkg::SPAN_W-1:0] tok_text_end;
  logic tok_has_text;

  ilt_pkg::out_t line_results[$];
  logic [7:0] line_buf[$];
  logic no_idle = 1'b0;
  int errors = 0;
  int results_checked = 0;
  int chars_sent = 0;
  int lines_by_status[4] = '{0, 0, 0, 0};

  function automatic void clear_line();
    tok_mode = ilt_pkg::MODE_INIT;
    tok_halted = 1'b0;
    tok_error = 1'b0;
    tok_pos = '0;
    tok_begin = '0;
    tok_end = '0;
    tok_sect_seen = 1'b0;
    tok_sect_lo = '0;
    tok_sect_hi = '0;
    tok_key_lo = '0;
    tok_key_hi = '0;
    tok_text_end = '0;
    tok_has_text = 1'b0;
  endfunction

  function automatic void advance_machine(input logic [7:0] c,
                                          input logic [ilt_pkg::SPAN_W-1:0] pos);
    ilt_pkg::mode_t m;
    m = tok_mode;
    case (c)
      ilt_pkg::CHAR_SPACE: ;
      ilt_pkg::CHAR_OPEN: begin
        if (m != ilt_pkg::MODE_TEXT) begin
          tok_begin = pos;
          m = ilt_pkg::MODE_OPEN;
        end
      end
      ilt_pkg::CHAR_CLOSE: begin
        if (m != ilt_pkg::MODE_TEXT) begin
          if (m != ilt_pkg::MODE_OPEN) begin
            tok_error = 1'b1;
            tok_halted = 1'b1;
            return;
          end
          m = ilt_pkg::MODE_CLOSED;
          tok_end = pos;
        end
      end
      ilt_pkg::CHAR_HASH: begin
        if (m == ilt_pkg::MODE_OPEN) begin
          tok_error = 1'b1;
          tok_halted = 1'b1;
          return;
        end
        m = ilt_pkg::MODE_COMMENT;
        tok_end = pos;
      end
      ilt_pkg::CHAR_EQUALS: begin
        if (m != ilt_pkg::MODE_OPEN && m != ilt_pkg::MODE_COMMENT) begin
          m = ilt_pkg::MODE_EQUALS;
          tok_end = pos;
        end
      end
      default: begin
        if (m == ilt_pkg::MODE_CLOSED) begin
          tok_error = 1'b1;
          tok_halted = 1'b1;
          return;
        end
        if (m == ilt_pkg::MODE_INIT || m == ilt_pkg::MODE_EQUALS) begin
          tok_begin = pos;
          m = ilt_pkg::MODE_TEXT;
        end
      end
    endcase
    tok_mode = m;
    if (m == ilt_pkg::MODE_COMMENT) begin
      tok_halted = 1'b1;
    end else if (m == ilt_pkg::MODE_CLOSED) begin
      tok_sect_seen = 1'b1;
      tok_sect_lo = tok_begin + 1'b1;
      tok_sect_hi = tok_end;
    end else if (m == ilt_pkg::MODE_EQUALS) begin
      tok_key_lo = tok_begin;
      tok_key_hi = tok_end;
    end
  endfunction

  function automatic logic tokenize_char(input logic [7:0] c, input logic last,
                                         output ilt_pkg::out_t res);
    logic [ilt_pkg::SPAN_W-1:0] pos;
    logic over;
    pos = tok_pos;
    over = (pos >= LINE_LIMIT);
    res = '0;
    if (!over) begin
      if (c != ilt_pkg::CHAR_SPACE) begin
        if (!tok_has_text) begin
          tok_has_text = 1'b1;
          tok_begin = pos;
        end
        tok_text_end = pos + 1'b1;
      end
      if (!tok_halted) advance_machine(c, pos);
      tok_pos = pos + 1'b1;
    end
    if (!last) return 1'b0;
    if (over) begin
      res.status = ilt_pkg::STATUS_TOO_LONG;
    end else if (!tok_has_text) begin
      res.status = ilt_pkg::STATUS_BLANK;
    end else begin
      res.status = tok_error ? ilt_pkg::STATUS_SYNTAX : ilt_pkg::STATUS_OK;
      if (tok_sect_seen) begin
        res.section_found = 1'b1;
        res.section_start = tok_sect_lo;
        res.section_stop = tok_sect_hi;
      end
      if (!tok_error && tok_key_hi > tok_key_lo) begin
        res.key_found = 1'b1;
        res.key_start = tok_key_lo;
        res.key_stop = tok_key_hi;
        if (tok_mode == ilt_pkg::MODE_COMMENT || tok_mode == ilt_pkg::MODE_TEXT) begin
          res.value_found = 1'b1;
          res.value_start = tok_begin;
          res.value_stop = (tok_end > tok_begin) ? tok_end : tok_text_end;
        end
      end
    end
    clear_line();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("line %0d %s: got %0d, expected %0d",
                                results_checked, name, got, want));
  endtask

  always @(posedge clk) begin
    ilt_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (line_results.size() == 0) begin
        report_mismatch("result arrived with no line pending");
      end else begin
        want = line_results.pop_front();
        check_field("status", int'(out_data.status), int'(want.status));
        check_field("section_found", int'(out_data.section_found),
                    int'(want.section_found));
        check_field("section_start", int'(out_data.section_start),
                    int'(want.section_start));
        check_field("section_stop", int'(out_data.section_stop), int'(want.section_stop));
        check_field("key_found", int'(out_data.key_found), int'(want.key_found));
        check_field("key_start", int'(out_data.key_start), int'(want.key_start));
        check_field("key_stop", int'(out_data.key_stop), int'(want.key_stop));
        check_field("value_found", int'(out_data.value_found), int'(want.value_found));
        check_field("value_start", int'(out_data.value_start), int'(want.value_start));
        check_field("value_stop", int'(out_data.value_stop), int'(want.value_stop));
      end
      results_checked++;
    end
    out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    ilt_pkg::out_t res;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{char_code: c, line_end: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    if (tokenize_char(c, last, res)) begin
      line_results = {line_results, res};
      lines_by_status[int'(res.status)]++;
    end
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++)
      send_char(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic add_char(input logic [7:0] c);
    line_buf = {line_buf, c};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_line();
  endtask

  task automatic add_repeat(input logic [7:0] c, input int n);
    repeat (n) add_char(c);
  endtask

  function automatic logic [7:0] pick_special();
    case ($urandom_range(4))
      0: return ilt_pkg::CHAR_SPACE;
      1: return ilt_pkg::CHAR_OPEN;
      2: return ilt_pkg::CHAR_CLOSE;
      3: return ilt_pkg::CHAR_HASH;
      default: return ilt_pkg::CHAR_EQUALS;
    endcase
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == ilt_pkg::CHAR_SPACE || c == ilt_pkg::CHAR_OPEN ||
           c == ilt_pkg::CHAR_CLOSE || c == ilt_pkg::CHAR_HASH ||
           c == ilt_pkg::CHAR_EQUALS);
    return c;
  endfunction

  task automatic add_word(input int n);
    repeat (n) add_char(pick_plain());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (line_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_lines();
    send_text("[sec]");
    send_text("  [ab]  # note");
    send_text("key=val");
    send_text(" k = v # trailing");
    send_text("a=b=c");
    send_text("=v");
    send_text("k=");
    send_text("k= v");
    send_text("k=v[x]");
    send_text("[a=b]");
    send_text("]");
    send_text("[a#b]");
    send_text("[s]x=1");
    send_text("[s] [t]");
    send_text("#only=comment");
    send_text("   ");
    send_text(" ");
    send_text("x");
    send_text("k=\tv\t");
    add_char(8'h00);
    add_char(ilt_pkg::CHAR_EQUALS);
    add_char(8'hFF);
    send_line();
  endtask

  task automatic test_long_lines();
    no_idle = 1'b1;
    add_text("k=");
    add_repeat("v", LINE_LIMIT - 1);
    send_line();
    no_idle = 1'b0;
    send_text("k=v");
  endtask

  task automatic test_random_lines();
    int stop_at;
    int kind;
    stop_at = chars_sent + RANDOM_CHARS;
    while (chars_sent < stop_at) begin
      kind = $urandom_range(99);
      add_repeat(ilt_pkg::CHAR_SPACE, $urandom_range(2));
      if (kind < 30) begin
        add_word($urandom_range(1, 6));
        add_repeat(ilt_pkg::CHAR_SPACE, $urandom_range(1));
        add_char(ilt_pkg::CHAR_EQUALS);
        add_repeat(ilt_pkg::CHAR_SPACE, $urandom_range(1));
        add_word($urandom_range(0, 6));
        if ($urandom_range(2) == 0) begin
          add_text(" #");
          add_word($urandom_range(0, 4));
        end
      end else if (kind < 45) begin
        add_char(ilt_pkg::CHAR_OPEN);
        add_word($urandom_range(0, 6));
        add_char(ilt_pkg::CHAR_CLOSE);
        add_repeat(ilt_pkg::CHAR_SPACE, $urandom_range(2));
        if ($urandom_range(2) == 0) begin
          add_char(ilt_pkg::CHAR_HASH);
          add_word($urandom_range(0, 4));
        end
      end else if (kind < 52) begin
        add_char(ilt_pkg::CHAR_HASH);
        add_word($urandom_range(0, 6));
      end else if (kind < 58) begin
        add_char(ilt_pkg::CHAR_SPACE);
      end else if (kind < 70) begin
        case ($urandom_range(5))
          0: add_text("]");
          1: begin add_text("["); add_word($urandom_range(0, 3)); add_text("#"); end
          2: begin add_text("[s]"); add_word($urandom_range(1, 3)); end
          3: begin add_word(2); add_text("=="); add_word(2); add_text("="); add_word(1); end
          4: begin add_text("["); add_word($urandom_range(0, 4)); end
          default: begin add_word($urandom_range(1, 3)); add_text("]=x"); end
        endcase
      end else if (kind < 78) begin
        add_word($urandom_range(1, 8));
      end else begin
        repeat ($urandom_range(1, 16)) begin
          if ($urandom_range(99) < 40) add_char(pick_special());
          else add_char(8'($urandom_range(255)));
        end
      end
      add_repeat(ilt_pkg::CHAR_SPACE, $urandom_range(2));
      send_line();
    end
  endtask

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    clear_line();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_lines();
    wait_drained();
    test_long_lines();
    test_random_lines();
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Tokenized %0d lines from %0d characters, with idle and backpressure gaps.",
             results_checked, chars_sent);
    $display("Line status mix: %0d ok, %0d syntax error, %0d blank, %0d too long.",
             lines_by_status[0], lines_by_status[1], lines_by_status[2], lines_by_status[3]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
